// ===== src/zlhw_pkg.sv =====
// Shared types and constants for the zip local header walker.
package zlhw_pkg;

    localparam logic [31:0] LOCAL_SIG = 32'h04034b50;

    localparam logic [1:0] KIND_NAME   = 2'd0;
    localparam logic [1:0] KIND_RECORD = 2'd1;
    localparam logic [1:0] KIND_STOP   = 2'd2;

    localparam int unsigned TDATA_W = 152;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  name_byte;
        logic        name_last;
        logic [31:0] data_offset;
        logic [31:0] packed_size;
        logic [31:0] plain_size;
        logic [15:0] method;
        logic [15:0] name_length;
        logic [15:0] entry_number;
    } t_result;

endpackage

// ===== src/zlhw_parser.sv =====
// Header parse state machine: one archive byte per accepted transaction.
module zlhw_parser
    import zlhw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_data_byte,
    input  logic        i_restart,
    output logic        o_res_valid,
    output t_result     o_res
);

    localparam logic [2:0] PH_SIG   = 3'd0;
    localparam logic [2:0] PH_HDR   = 3'd1;
    localparam logic [2:0] PH_NAME  = 3'd2;
    localparam logic [2:0] PH_EXTRA = 3'd3;
    localparam logic [2:0] PH_FIRST = 3'd4;
    localparam logic [2:0] PH_DATA  = 3'd5;
    localparam logic [2:0] PH_STOP  = 3'd6;

    logic [2:0]  r_phase,     n_phase;
    logic [4:0]  r_hidx,      n_hidx;
    logic [31:0] r_pos,       n_pos;
    logic [23:0] r_sig,       n_sig;
    logic [31:0] r_packed,    n_packed;
    logic [31:0] r_plain,     n_plain;
    logic [15:0] r_method,    n_method;
    logic [15:0] r_name_len,  n_name_len;
    logic [15:0] r_extra_len, n_extra_len;
    logic [31:0] r_remain,    n_remain;
    logic [15:0] r_count,     n_count;

    logic [2:0]  cur_phase;
    logic [4:0]  cur_hidx;
    logic [31:0] cur_pos;
    logic [31:0] rem_dec;
    logic [31:0] pk_dec;
    logic [31:0] sig_full;

    always_comb begin
        cur_phase = i_restart ? PH_SIG : r_phase;
        cur_hidx  = i_restart ? 5'd0 : r_hidx;
        cur_pos   = i_restart ? 32'd0 : r_pos;
        rem_dec   = r_remain - 32'd1;
        pk_dec    = r_packed - 32'd1;
        sig_full  = {i_data_byte, r_sig};

        n_phase     = cur_phase;
        n_hidx      = cur_hidx;
        n_pos       = cur_pos + 32'd1;
        n_sig       = r_sig;
        n_packed    = r_packed;
        n_plain     = r_plain;
        n_method    = r_method;
        n_name_len  = r_name_len;
        n_extra_len = r_extra_len;
        n_remain    = r_remain;
        n_count     = r_count;

        o_res_valid = 1'b0;
        o_res       = '0;

        unique case (cur_phase)
            PH_SIG: begin
                case (cur_hidx[1:0])
                    2'd0: n_sig = {16'd0, i_data_byte};
                    2'd1: n_sig[15:8] = i_data_byte;
                    2'd2: n_sig[23:16] = i_data_byte;
                    default: n_sig = r_sig;
                endcase
                n_hidx = cur_hidx + 5'd1;
                if (cur_hidx == 5'd3) begin
                    if (sig_full != LOCAL_SIG) begin
                        n_phase     = PH_STOP;
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_STOP;
                    end else begin
                        n_phase = PH_HDR;
                        n_hidx  = 5'd4;
                    end
                end
            end
            PH_HDR: begin
                case (cur_hidx)
                    5'd8:  n_method = {8'd0, i_data_byte};
                    5'd9:  n_method[15:8] = i_data_byte;
                    5'd18: n_packed = {24'd0, i_data_byte};
                    5'd19: n_packed[15:8] = i_data_byte;
                    5'd20: n_packed[23:16] = i_data_byte;
                    5'd21: n_packed[31:24] = i_data_byte;
                    5'd22: n_plain = {24'd0, i_data_byte};
                    5'd23: n_plain[15:8] = i_data_byte;
                    5'd24: n_plain[23:16] = i_data_byte;
                    5'd25: n_plain[31:24] = i_data_byte;
                    5'd26: n_name_len = {8'd0, i_data_byte};
                    5'd27: n_name_len[15:8] = i_data_byte;
                    5'd28: n_extra_len = {8'd0, i_data_byte};
                    5'd29: n_extra_len[15:8] = i_data_byte;
                    default: n_method = r_method;
                endcase
                if (cur_hidx >= 5'd29) begin
                    n_hidx = 5'd0;
                    if (n_name_len != 16'd0) begin
                        n_phase  = PH_NAME;
                        n_remain = {16'd0, n_name_len};
                    end else if (n_extra_len != 16'd0) begin
                        n_phase  = PH_EXTRA;
                        n_remain = {16'd0, n_extra_len};
                    end else begin
                        n_phase = (n_packed != 32'd0) ? PH_FIRST : PH_SIG;
                    end
                end else begin
                    n_hidx = cur_hidx + 5'd1;
                end
            end
            PH_NAME: begin
                o_res_valid     = 1'b1;
                o_res.kind      = KIND_NAME;
                o_res.name_byte = i_data_byte;
                o_res.name_last = (rem_dec == 32'd0);
                n_remain        = rem_dec;
                if (rem_dec == 32'd0) begin
                    if (r_extra_len != 16'd0) begin
                        n_phase  = PH_EXTRA;
                        n_remain = {16'd0, r_extra_len};
                    end else begin
                        n_phase = (r_packed != 32'd0) ? PH_FIRST : PH_SIG;
                        n_hidx  = 5'd0;
                    end
                end
            end
            PH_EXTRA: begin
                n_remain = rem_dec;
                if (rem_dec == 32'd0) begin
                    n_phase = (r_packed != 32'd0) ? PH_FIRST : PH_SIG;
                    n_hidx  = 5'd0;
                end
            end
            PH_FIRST: begin
                o_res_valid        = 1'b1;
                o_res.kind         = KIND_RECORD;
                o_res.data_offset  = cur_pos;
                o_res.packed_size  = r_packed;
                o_res.plain_size   = r_plain;
                o_res.method       = r_method;
                o_res.name_length  = r_name_len;
                o_res.entry_number = r_count;
                n_count            = r_count + 16'd1;
                n_remain           = pk_dec;
                n_phase            = (pk_dec == 32'd0) ? PH_SIG : PH_DATA;
                n_hidx             = 5'd0;
            end
            PH_DATA: begin
                n_remain = rem_dec;
                if (rem_dec == 32'd0) begin
                    n_phase = PH_SIG;
                    n_hidx  = 5'd0;
                end
            end
            default: begin
                n_phase = cur_phase;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SIG;
            r_hidx      <= 5'd0;
            r_pos       <= 32'd0;
            r_sig       <= 24'd0;
            r_packed    <= 32'd0;
            r_plain     <= 32'd0;
            r_method    <= 16'd0;
            r_name_len  <= 16'd0;
            r_extra_len <= 16'd0;
            r_remain    <= 32'd0;
            r_count     <= 16'd0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_hidx      <= n_hidx;
            r_pos       <= n_pos;
            r_sig       <= n_sig;
            r_packed    <= n_packed;
            r_plain     <= n_plain;
            r_method    <= n_method;
            r_name_len  <= n_name_len;
            r_extra_len <= n_extra_len;
            r_remain    <= n_remain;
            r_count     <= n_count;
        end
    end

endmodule

// ===== src/zlhw_out_buf.sv =====
// Two-entry result register with skid slot toward the output stream.
module zlhw_out_buf
    import zlhw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_v0, n_v0;
    logic    r_v1, n_v1;
    t_result r_q0, n_q0;
    t_result r_q1, n_q1;
    logic    pop;

    assign pop     = r_v0 && i_ready;
    assign o_space = !r_v1;
    assign o_valid = r_v0;
    assign o_res   = r_q0;

    always_comb begin
        n_v0 = r_v0;
        n_v1 = r_v1;
        n_q0 = r_q0;
        n_q1 = r_q1;
        if (pop) begin
            n_q0 = r_q1;
            n_v0 = r_v1;
            n_v1 = 1'b0;
        end
        if (i_push) begin
            if (!n_v0) begin
                n_q0 = i_res;
                n_v0 = 1'b1;
            end else begin
                n_q1 = i_res;
                n_v1 = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
        end
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

endmodule

// ===== src/zip_local_header_walker_top.sv =====
// Top level of the zip local header walker.
//
// Input stream: one archive byte per transaction on tdata; tuser set marks
// the first byte of a new archive and clears position and parse phase
// (the entry counter is kept). Output stream: tuser carries the result
// kind (name byte, entry record, stop on bad signature); tlast flags the
// final name byte of an entry; tdata packs the remaining fields.
// Each byte is parsed in the cycle it is accepted and its result, if any,
// is registered in the output buffer and then presented. Throughput is one
// byte per cycle while the output buffer has space, set by the combinational
// parse step and the two-entry output register. A stalled receiver holds the
// head result; the input keeps accepting until the second output slot is
// occupied, then tready drops. Entry records appear on the first compressed
// data byte; folders give none. After a bad signature bytes are dropped
// until a restart byte. Reset (synchronous, active low) clears the parse
// state, position, entry counter and both output slots.
module zip_local_header_walker_top
    import zlhw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [7:0]         i_s_axis_tdata,  // data_byte[7:0]
    input  logic               i_s_axis_tuser,  // restart[0]
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    // name_byte[7:0], data_offset[39:8], packed_size[71:40], plain_size[103:72],
    // method[119:104], name_length[135:120], entry_number[151:136]
    output logic [TDATA_W-1:0] o_m_axis_tdata,
    output logic [1:0]         o_m_axis_tuser,  // kind[1:0]
    output logic               o_m_axis_tlast
);

    logic    accept;
    logic    space;
    logic    res_valid;
    t_result res;
    t_result head;

    assign o_s_axis_tready = space;
    assign accept          = i_s_axis_tvalid && space;

    zlhw_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_s_axis_tdata),
        .i_restart   (i_s_axis_tuser),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    zlhw_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && res_valid),
        .i_res   (res),
        .o_space (space),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (head)
    );

    assign o_m_axis_tuser = head.kind;
    assign o_m_axis_tlast = head.name_last;
    assign o_m_axis_tdata = {head.entry_number, head.name_length, head.method,
                             head.plain_size, head.packed_size, head.data_offset,
                             head.name_byte};

endmodule
